>>> hw/rtl/tcdc_pkg.sv
// Package with the constants and helper functions of the terminal colour depth converter.
package tcdc_pkg;

	localparam logic [1:0] MODE_DEFAULT = 2'd0;
	localparam logic [1:0] MODE_BASIC   = 2'd1;
	localparam logic [1:0] MODE_PALETTE = 2'd2;
	localparam logic [1:0] MODE_RGB     = 2'd3;

	localparam logic [1:0] DEPTH_BASIC = 2'd0;
	localparam logic [1:0] DEPTH_256   = 2'd1;
	localparam logic [1:0] DEPTH_TRUE  = 2'd2;

	localparam logic [7:0] CUBE_BASE     = 8'd16;
	localparam logic [7:0] GRAY_BASE     = 8'd232;
	localparam logic [7:0] GRAY_LOW      = 8'd4;
	localparam logic [7:0] GRAY_HIGH     = 8'd243;
	localparam logic [4:0] GRAY_K_MAX    = 5'd23;
	localparam logic [7:0] GRAY_BRIGHT   = 8'd128;
	localparam logic [7:0] STEP1_EDGE    = 8'd48;
	localparam logic [7:0] STEP2_EDGE    = 8'd115;
	localparam logic [7:0] STEP3_EDGE    = 8'd155;
	localparam logic [7:0] STEP4_EDGE    = 8'd195;
	localparam logic [7:0] STEP5_EDGE    = 8'd235;

	function automatic logic [2:0] comp_step(input logic [7:0] c);
		logic [2:0] s;
		if (c < STEP1_EDGE) begin
			s = 3'd0;
		end else if (c < STEP2_EDGE) begin
			s = 3'd1;
		end else if (c < STEP3_EDGE) begin
			s = 3'd2;
		end else if (c < STEP4_EDGE) begin
			s = 3'd3;
		end else if (c < STEP5_EDGE) begin
			s = 3'd4;
		end else begin
			s = 3'd5;
		end
		return s;
	endfunction

	function automatic logic [7:0] cube_level(input logic [2:0] s);
		logic [7:0] l;
		case (s)
			3'd0: l = 8'h00;
			3'd1: l = 8'h5f;
			3'd2: l = 8'h87;
			3'd3: l = 8'haf;
			3'd4: l = 8'hd7;
			default: l = 8'hff;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

>>> hw/rtl/terminal_color_depth_converter_unit.sv
// Terminal colour depth converter: five-stage pipeline from colour description to colour value.
// Throughput is one beat per cycle; each stage holds while the stage after it is full and stalled.
// The stages are digit extraction, cube distance and mean, gray level, gray distance, and selection.
// Reset clears every stage valid bit and sets the terminal depth to the 256 colour palette.
module terminal_color_depth_converter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [7:0]         palette_index,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [24:0] color_value
);

	logic [1:0] depth_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5      = !v_s5 || !out_stall;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= tcdc_pkg::DEPTH_256;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: component steps, cube differences, component sum and palette digits.
	logic [7:0]  pn;
	logic [16:0] pq36_prod;
	logic [2:0]  pq36;
	logic [7:0]  prem;
	logic [2:0]  sr, sg, sb;

	assign pn        = palette_index - tcdc_pkg::CUBE_BASE;
	assign pq36_prod = {9'd0, pn} * 17'd456;
	assign pq36      = pq36_prod[16:14];
	assign prem      = pn - ({5'd0, pq36} * 8'd36);
	assign sr        = tcdc_pkg::comp_step(red);
	assign sg        = tcdc_pkg::comp_step(green);
	assign sb        = tcdc_pkg::comp_step(blue);

	logic [1:0] mode_s1;
	logic [7:0] idx_s1, r_s1, g_s1, b_s1;
	logic [2:0] sr_s1, sg_s1, sb_s1;
	logic [7:0] dr_s1, dg_s1, db_s1;
	logic [9:0] sum_s1;
	logic [2:0] pd_r_s1;
	logic [7:0] prem_s1;
	logic       pgray_s1;
	logic [7:0] plvl_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1  <= mode;
			idx_s1   <= palette_index;
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			sr_s1    <= sr;
			sg_s1    <= sg;
			sb_s1    <= sb;
			dr_s1    <= tcdc_pkg::abs_diff(red, tcdc_pkg::cube_level(sr));
			dg_s1    <= tcdc_pkg::abs_diff(green, tcdc_pkg::cube_level(sg));
			db_s1    <= tcdc_pkg::abs_diff(blue, tcdc_pkg::cube_level(sb));
			sum_s1   <= {2'd0, red} + {2'd0, green} + {2'd0, blue};
			pd_r_s1  <= pq36;
			prem_s1  <= prem;
			pgray_s1 <= palette_index >= tcdc_pkg::GRAY_BASE;
			plvl_s1  <= 8'd8 + 8'((palette_index - tcdc_pkg::GRAY_BASE) * 8'd10);
		end
	end

	// Stage 2: cube distance, mean of the components, palette expansion.
	logic [19:0] avg_prod;
	logic [13:0] pq6_prod;
	logic [2:0]  pq6;
	logic [7:0]  pb_full;
	logic [2:0]  pd_b;

	assign avg_prod = {10'd0, sum_s1} * 20'd683;
	assign pq6_prod = {6'd0, prem_s1} * 14'd43;
	assign pq6      = pq6_prod[10:8];
	assign pb_full  = prem_s1 - ({5'd0, pq6} * 8'd6);
	assign pd_b     = pb_full[2:0];

	logic [1:0]  mode_s2;
	logic [7:0]  idx_s2, r_s2, g_s2, b_s2;
	logic [2:0]  sr_s2, sg_s2, sb_s2;
	logic [17:0] cube_d_s2;
	logic [7:0]  avg_s2;
	logic [23:0] pal_rgb_s2;
	logic [2:0]  pal_basic_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2   <= mode_s1;
			idx_s2    <= idx_s1;
			r_s2      <= r_s1;
			g_s2      <= g_s1;
			b_s2      <= b_s1;
			sr_s2     <= sr_s1;
			sg_s2     <= sg_s1;
			sb_s2     <= sb_s1;
			cube_d_s2 <= ({10'd0, dr_s1} * {10'd0, dr_s1}) + ({10'd0, dg_s1} * {10'd0, dg_s1})
			             + ({10'd0, db_s1} * {10'd0, db_s1});
			avg_s2    <= avg_prod[18:11];
			if (pgray_s1) begin
				pal_rgb_s2   <= {plvl_s1, plvl_s1, plvl_s1};
				pal_basic_s2 <= (plvl_s1 > tcdc_pkg::GRAY_BRIGHT) ? 3'd7 : 3'd0;
			end else begin
				pal_rgb_s2   <= {tcdc_pkg::cube_level(pd_r_s1), tcdc_pkg::cube_level(pq6),
				                 tcdc_pkg::cube_level(pd_b)};
				pal_basic_s2 <= {pd_b > 3'd1, pq6 > 3'd1, pd_r_s1 > 3'd1};
			end
		end
	end

	// Stage 3: gray ramp index, level and differences.
	logic [7:0]  kx;
	logic [15:0] k_prod;
	logic [4:0]  k;
	logic [7:0]  lvl;

	assign kx     = avg_s2 - tcdc_pkg::GRAY_LOW;
	assign k_prod = {8'd0, kx} * 16'd205;
	always_comb begin
		if (avg_s2 < tcdc_pkg::GRAY_LOW) begin
			k = 5'd0;
		end else if (avg_s2 > tcdc_pkg::GRAY_HIGH) begin
			k = tcdc_pkg::GRAY_K_MAX;
		end else begin
			k = k_prod[15:11];
		end
	end
	assign lvl = 8'd8 + ({3'd0, k} * 8'd10);

	logic [1:0]  mode_s3;
	logic [7:0]  idx_s3, r_s3, g_s3, b_s3;
	logic [2:0]  sr_s3, sg_s3, sb_s3;
	logic [17:0] cube_d_s3;
	logic [4:0]  k_s3;
	logic [7:0]  lvl_s3;
	logic [7:0]  gdr_s3, gdg_s3, gdb_s3;
	logic [23:0] pal_rgb_s3;
	logic [2:0]  pal_basic_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3      <= mode_s2;
			idx_s3       <= idx_s2;
			r_s3         <= r_s2;
			g_s3         <= g_s2;
			b_s3         <= b_s2;
			sr_s3        <= sr_s2;
			sg_s3        <= sg_s2;
			sb_s3        <= sb_s2;
			cube_d_s3    <= cube_d_s2;
			k_s3         <= k;
			lvl_s3       <= lvl;
			gdr_s3       <= tcdc_pkg::abs_diff(r_s2, lvl);
			gdg_s3       <= tcdc_pkg::abs_diff(g_s2, lvl);
			gdb_s3       <= tcdc_pkg::abs_diff(b_s2, lvl);
			pal_rgb_s3   <= pal_rgb_s2;
			pal_basic_s3 <= pal_basic_s2;
		end
	end

	// Stage 4: gray distance and the choice between gray and cube.
	logic [17:0] gray_d;
	assign gray_d = ({10'd0, gdr_s3} * {10'd0, gdr_s3}) + ({10'd0, gdg_s3} * {10'd0, gdg_s3})
	                + ({10'd0, gdb_s3} * {10'd0, gdb_s3});

	logic [1:0]  mode_s4;
	logic [7:0]  idx_s4, r_s4, g_s4, b_s4;
	logic [7:0]  qidx_s4;
	logic [2:0]  qbasic_s4;
	logic [23:0] pal_rgb_s4;
	logic [2:0]  pal_basic_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			mode_s4      <= mode_s3;
			idx_s4       <= idx_s3;
			r_s4         <= r_s3;
			g_s4         <= g_s3;
			b_s4         <= b_s3;
			pal_rgb_s4   <= pal_rgb_s3;
			pal_basic_s4 <= pal_basic_s3;
			if (gray_d < cube_d_s3) begin
				qidx_s4   <= tcdc_pkg::GRAY_BASE + {3'd0, k_s3};
				qbasic_s4 <= (lvl_s3 > tcdc_pkg::GRAY_BRIGHT) ? 3'd7 : 3'd0;
			end else begin
				qidx_s4   <= tcdc_pkg::CUBE_BASE + ({5'd0, sr_s3} * 8'd36)
				             + ({5'd0, sg_s3} * 8'd6) + {5'd0, sb_s3};
				qbasic_s4 <= {sb_s3 > 3'd1, sg_s3 > 3'd1, sr_s3 > 3'd1};
			end
		end
	end

	// Stage 5: selection of the result by colour kind and terminal depth.
	logic [24:0] res;
	always_comb begin
		case (mode_s4)
			tcdc_pkg::MODE_DEFAULT: res = '1;
			tcdc_pkg::MODE_BASIC:   res = {17'd0, idx_s4};
			tcdc_pkg::MODE_PALETTE: begin
				if (idx_s4 < tcdc_pkg::CUBE_BASE) begin
					res = {17'd0, idx_s4};
				end else begin
					case (depth_q)
						tcdc_pkg::DEPTH_TRUE:  res = {1'b0, pal_rgb_s4};
						tcdc_pkg::DEPTH_BASIC: res = {22'd0, pal_basic_s4};
						default:               res = {17'd0, idx_s4};
					endcase
				end
			end
			default: begin
				case (depth_q)
					tcdc_pkg::DEPTH_TRUE:  res = {1'b0, r_s4, g_s4, b_s4};
					tcdc_pkg::DEPTH_BASIC: res = {22'd0, qbasic_s4};
					default:               res = {17'd0, qidx_s4};
				endcase
			end
		endcase
	end

	logic [24:0] out_s5;
	always_ff @(posedge clk) begin
		if (en5) begin
			out_s5 <= res;
		end
	end

	assign out_valid   = v_s5;
	assign color_value = $signed(out_s5);

endmodule
